// ----- hw/rtl/pbm_pkg.sv -----
// Shared types and constants for the PBM bitmap stream decoder.
`default_nettype none

package pbm_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_PIXEL     = 2'd0;
    localparam logic [1:0] KIND_HEADER    = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
    localparam logic [1:0] KIND_DIM_ERROR = 2'd3;

    // Characters the parser looks for.
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_FOUR = 8'h34;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Parser phase, one-hot.
    typedef enum logic [3:0] {
        PH_MAGIC  = 4'b0001,
        PH_WIDTH  = 4'b0010,
        PH_HEIGHT = 4'b0100,
        PH_RASTER = 4'b1000
    } phase_t;

    // One unit of work from the parser: a single result, or a run of up to
    // eight pixels taken MSB first from data.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] column;
        logic [15:0] row;
        logic [15:0] width;
        logic [15:0] height;
        logic        end_of_image;
        logic [3:0]  count;
    } job_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
               (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
    endfunction

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pbm_front.sv -----
// Header parser and raster classifier: turns each accepted byte into at most one job.
`default_nettype none

module pbm_front #(
    parameter int MAX_DIM = 65535
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    data_byte,
    output pbm_pkg::job_t      job,
    output logic               job_valid
);

    localparam int         LIM_INT = (MAX_DIM > 65535) ? 65535 : MAX_DIM;
    localparam logic [16:0] LIM    = 17'(LIM_INT);
    localparam logic [16:0] LIM_P1 = 17'(LIM_INT + 1);

    pbm_pkg::phase_t phase_reg, phase_next;
    logic        binary_reg, binary_next;
    logic        in_comment_reg, in_comment_next;
    logic        in_token_reg, in_token_next;
    logic [1:0]  token_length_reg, token_length_next;
    logic        magic_ok_reg, magic_ok_next;
    logic        digits_ended_reg, digits_ended_next;
    logic [16:0] number_accum_reg, number_accum_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;

    always_comb
    begin
        logic [1:0]  tl;
        logic        mo;
        logic        de;
        logic [16:0] acc;
        logic [20:0] prod;
        logic [15:0] rem;
        logic [16:0] row_inc;
        logic        row_end;
        logic        space;

        tl      = token_length_reg;
        mo      = magic_ok_reg;
        de      = digits_ended_reg;
        acc     = number_accum_reg;
        prod    = '0;
        rem     = width_reg - col_reg;
        row_inc = {1'b0, row_reg} + 17'd1;
        row_end = 1'b0;
        space   = pbm_pkg::is_space(data_byte);

        phase_next        = phase_reg;
        binary_next       = binary_reg;
        in_comment_next   = in_comment_reg;
        in_token_next     = in_token_reg;
        token_length_next = token_length_reg;
        magic_ok_next     = magic_ok_reg;
        digits_ended_next = digits_ended_reg;
        number_accum_next = number_accum_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        job               = '0;
        job_valid         = 1'b0;

        if (byte_valid)
        begin
            case (phase_reg)
                pbm_pkg::PH_RASTER:
                begin
                    if (binary_reg || !space)
                    begin
                        if (binary_reg)
                        begin
                            // A row ending inside this byte drops the padding bits.
                            row_end   = (rem <= 16'd8);
                            job.count = row_end ? rem[3:0] : 4'd8;
                            job.data  = data_byte;
                        end
                        else
                        begin
                            row_end   = (rem == 16'd1);
                            job.count = 4'd1;
                            job.data  = {(data_byte == pbm_pkg::CHAR_ONE), 7'b0};
                        end
                        job_valid  = 1'b1;
                        job.kind   = pbm_pkg::KIND_PIXEL;
                        job.column = col_reg;
                        job.row    = row_reg;
                        job.width  = width_reg;
                        job.height = height_reg;
                        if (row_end)
                        begin
                            col_next = '0;
                            row_next = row_inc[15:0];
                            if (row_inc >= {1'b0, height_reg})
                            begin
                                phase_next       = pbm_pkg::PH_MAGIC;
                                job.end_of_image = 1'b1;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + {12'b0, job.count};
                        end
                    end
                end
                pbm_pkg::PH_MAGIC, pbm_pkg::PH_WIDTH, pbm_pkg::PH_HEIGHT:
                begin
                    if (in_comment_reg)
                    begin
                        if (data_byte == pbm_pkg::CHAR_LF)
                        begin
                            in_comment_next = 1'b0;
                        end
                    end
                    else if (space)
                    begin
                        if (in_token_reg)
                        begin
                            in_token_next = 1'b0;
                            job.count     = 4'd1;
                            case (phase_reg)
                                pbm_pkg::PH_MAGIC:
                                begin
                                    if (magic_ok_reg && token_length_reg == 2'd2)
                                    begin
                                        phase_next = pbm_pkg::PH_WIDTH;
                                    end
                                    else
                                    begin
                                        job_valid = 1'b1;
                                        job.kind  = pbm_pkg::KIND_BAD_MAGIC;
                                    end
                                end
                                pbm_pkg::PH_WIDTH:
                                begin
                                    if (number_accum_reg > LIM)
                                    begin
                                        job_valid  = 1'b1;
                                        job.kind   = pbm_pkg::KIND_DIM_ERROR;
                                        job.width  = pbm_pkg::sat16(number_accum_reg);
                                        phase_next = pbm_pkg::PH_MAGIC;
                                    end
                                    else
                                    begin
                                        width_next = number_accum_reg[15:0];
                                        phase_next = pbm_pkg::PH_HEIGHT;
                                    end
                                end
                                default:
                                begin
                                    job_valid = 1'b1;
                                    if (number_accum_reg > LIM)
                                    begin
                                        job.kind   = pbm_pkg::KIND_DIM_ERROR;
                                        job.width  = width_reg;
                                        job.height = pbm_pkg::sat16(number_accum_reg);
                                        phase_next = pbm_pkg::PH_MAGIC;
                                    end
                                    else
                                    begin
                                        height_next      = number_accum_reg[15:0];
                                        col_next         = '0;
                                        row_next         = '0;
                                        job.kind         = pbm_pkg::KIND_HEADER;
                                        job.width        = width_reg;
                                        job.height       = number_accum_reg[15:0];
                                        job.end_of_image = (width_reg == 16'd0) ||
                                                           (number_accum_reg == 17'd0);
                                        phase_next       = job.end_of_image ?
                                                           pbm_pkg::PH_MAGIC :
                                                           pbm_pkg::PH_RASTER;
                                    end
                                end
                            endcase
                        end
                    end
                    else if (!in_token_reg && data_byte == pbm_pkg::CHAR_HASH)
                    begin
                        in_comment_next = 1'b1;
                    end
                    else
                    begin
                        if (!in_token_reg)
                        begin
                            tl  = 2'd0;
                            mo  = 1'b1;
                            de  = 1'b0;
                            acc = '0;
                        end
                        in_token_next = 1'b1;
                        if (phase_reg == pbm_pkg::PH_MAGIC)
                        begin
                            case (tl)
                                2'd0:
                                begin
                                    if (data_byte != pbm_pkg::CHAR_P)
                                    begin
                                        mo = 1'b0;
                                    end
                                end
                                2'd1:
                                begin
                                    if (data_byte == pbm_pkg::CHAR_ONE)
                                    begin
                                        binary_next = 1'b0;
                                    end
                                    else if (data_byte == pbm_pkg::CHAR_FOUR)
                                    begin
                                        binary_next = 1'b1;
                                    end
                                    else
                                    begin
                                        mo = 1'b0;
                                    end
                                end
                                default:
                                begin
                                    mo = 1'b0;
                                end
                            endcase
                            if (tl != 2'd3)
                            begin
                                tl = tl + 2'd1;
                            end
                        end
                        else if (!de && data_byte >= pbm_pkg::CHAR_ZERO &&
                                 data_byte <= pbm_pkg::CHAR_NINE)
                        begin
                            // The value saturates one above the limit so that it stays narrow.
                            prod = {4'b0, acc} * 21'd10 + {17'b0, data_byte[3:0]};
                            acc  = (prod > {4'b0, LIM_P1}) ? LIM_P1 : prod[16:0];
                        end
                        else
                        begin
                            de = 1'b1;
                        end
                        token_length_next = tl;
                        magic_ok_next     = mo;
                        digits_ended_next = de;
                        number_accum_next = acc;
                    end
                end
                default:
                begin
                    phase_next = pbm_pkg::PH_MAGIC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= pbm_pkg::PH_MAGIC;
            binary_reg       <= 1'b0;
            in_comment_reg   <= 1'b0;
            in_token_reg     <= 1'b0;
            token_length_reg <= '0;
            magic_ok_reg     <= 1'b0;
            digits_ended_reg <= 1'b0;
            number_accum_reg <= '0;
            width_reg        <= '0;
            height_reg       <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            binary_reg       <= binary_next;
            in_comment_reg   <= in_comment_next;
            in_token_reg     <= in_token_next;
            token_length_reg <= token_length_next;
            magic_ok_reg     <= magic_ok_next;
            digits_ended_reg <= digits_ended_next;
            number_accum_reg <= number_accum_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
        end
    end

    // A comment can only open between tokens.
    a_comment_outside_token: assert property (@(posedge clk) disable iff (!rst_n)
        in_comment_reg |-> !in_token_reg)
        else $error("comment and token open at once");

    // In the raster the column always stays inside the row.
    a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pbm_pkg::PH_RASTER) |-> (col_reg < width_reg))
        else $error("raster column outside the row");

endmodule

`default_nettype wire

// ----- hw/rtl/pbm_jobq.sv -----
// Short job queue between the parser and the pixel unpacker.
`default_nettype none

module pbm_jobq #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire pbm_pkg::job_t wr_job,
    output logic               full,
    input  wire logic          rd,
    output pbm_pkg::job_t      rd_job,
    output logic               rd_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    pbm_pkg::job_t   mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign full     = (count_reg == DEPTH_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem[rd_ptr_reg];
    assign do_wr    = wr && !full;
    assign do_rd    = rd && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("job queue count overflow");

    // The parser is gated by full, so a job must never be dropped.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full))
        else $error("job written into a full queue");

endmodule

`default_nettype wire

// ----- hw/rtl/pbm_back.sv -----
// Pixel unpacker: expands each job into results and holds one in an output register.
`default_nettype none

module pbm_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pbm_pkg::job_t head,
    input  wire logic          head_valid,
    output logic               head_pop,
    output logic               empty,
    input  wire logic          pop,
    output logic [1:0]         kind,
    output logic               pixel,
    output logic [15:0]        column,
    output logic [15:0]        row,
    output logic [15:0]        width,
    output logic [15:0]        height,
    output logic               end_of_image,
    output logic               last
);

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  idx_reg, idx_next;
    logic        load;
    logic        final_one;
    logic [7:0]  shifted;

    logic [1:0]  kind_reg;
    logic        pixel_reg;
    logic [15:0] column_reg;
    logic [15:0] row_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic        eoi_reg;
    logic        last_reg;

    assign load      = head_valid && (!out_valid_reg || pop);
    assign final_one = ({1'b0, idx_reg} + 4'd1) == head.count;
    assign head_pop  = load && final_one;
    assign shifted   = head.data << idx_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = final_one ? 3'd0 : idx_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= head.kind;
            pixel_reg  <= shifted[7];
            column_reg <= head.column + {13'b0, idx_reg};
            row_reg    <= head.row;
            width_reg  <= head.width;
            height_reg <= head.height;
            eoi_reg    <= head.end_of_image && final_one;
            last_reg   <= final_one;
        end
    end

    assign empty        = !out_valid_reg;
    assign kind         = kind_reg;
    assign pixel        = pixel_reg;
    assign column       = column_reg;
    assign row          = row_reg;
    assign width        = width_reg;
    assign height       = height_reg;
    assign end_of_image = eoi_reg;
    assign last         = last_reg;

    // The image end is always the final result of its input byte.
    a_eoi_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eoi_reg) |-> last_reg)
        else $error("end of image without last");

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, idx_reg} < head.count))
        else $error("unpack index past job length");

endmodule

`default_nettype wire

// ----- hw/rtl/pbm_bitmap_stream_decoder.sv -----
// Top level of the PBM (P1/P4) bitmap stream decoder.
//
//   channel   direction  handshake          payload
//   input     in         push / full        data_byte
//   result    out        empty / pop        kind, pixel, column, row, width, height,
//                                           end_of_image, last
//
// The parser takes one byte per cycle and turns it into at most one job in a
// QUEUE_DEPTH entry queue, stalling only when the queue is full. The unpacker
// issues one result per cycle, stalling only while a result waits to be popped,
// so a binary raster byte gives up to eight results and any other byte at most one.
// The queue head job is loaded into the result register whenever it is empty.
// Reset needs no sweep.
`default_nettype none

module pbm_bitmap_stream_decoder #(
    parameter int MAX_DIM     = 65535,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic             pixel,
    output logic [15:0]      column,
    output logic [15:0]      row,
    output logic [15:0]      width,
    output logic [15:0]      height,
    output logic             end_of_image,
    output logic             last
);

    pbm_pkg::job_t front_job;
    pbm_pkg::job_t head_job;
    logic          front_valid;
    logic          head_valid;
    logic          head_pop;
    logic          accept;

    assign accept = push && !full;

    pbm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (accept),
        .data_byte  (data_byte),
        .job        (front_job),
        .job_valid  (front_valid)
    );

    pbm_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (front_valid),
        .wr_job   (front_job),
        .full     (full),
        .rd       (head_pop),
        .rd_job   (head_job),
        .rd_valid (head_valid)
    );

    pbm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_job),
        .head_valid   (head_valid),
        .head_pop     (head_pop),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .pixel        (pixel),
        .column       (column),
        .row          (row),
        .width        (width),
        .height       (height),
        .end_of_image (end_of_image),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- bench/pbm_bitmap_stream_decoder_tb.sv -----
// Self-checking testbench for the PBM bitmap stream decoder, with its scoreboard class.

typedef struct packed {
    logic [1:0]  kind;
    logic        pixel;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] width;
    logic [15:0] height;
    logic        end_of_image;
    logic        last;
} pbm_result_t;

function automatic bit is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C || b == 8'h0D;
endfunction

class pbm_scoreboard;
    localparam int unsigned DIM_LIMIT = 65535;

    pbm_pkg::phase_t phase;
    bit binary_mode;
    bit in_comment;
    bit in_token;
    bit magic_ok;
    bit digits_ended;
    bit [1:0] token_len;
    int unsigned number;
    int unsigned img_width;
    int unsigned img_height;
    int unsigned col_count;
    int unsigned row_count;

    pbm_result_t byte_results[$];
    pbm_result_t awaited_results[$];
    int errors;
    int checked;

    function new();
        phase = pbm_pkg::PH_MAGIC;
        errors = 0;
        checked = 0;
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    function void add_result(logic [1:0] k, logic pix, int unsigned c, int unsigned r,
                             int unsigned w, int unsigned h, logic eoi);
        pbm_result_t res;
        res.kind = k;
        res.pixel = pix;
        res.column = c[15:0];
        res.row = r[15:0];
        res.width = w[15:0];
        res.height = h[15:0];
        res.end_of_image = eoi;
        res.last = 1'b0;
        byte_results.push_back(res);
    endfunction

    function void add_pixel(logic pix);
        int unsigned c;
        int unsigned r;
        logic eoi;
        c = col_count;
        r = row_count;
        eoi = 1'b0;
        col_count++;
        if (col_count >= img_width)
        begin
            col_count = 0;
            row_count++;
            if (row_count >= img_height)
            begin
                eoi = 1'b1;
                phase = pbm_pkg::PH_MAGIC;
            end
        end
        add_result(pbm_pkg::KIND_PIXEL, pix, c, r, img_width, img_height, eoi);
    endfunction

    function int unsigned clip16(int unsigned v);
        return (v > 65535) ? 65535 : v;
    endfunction

    function void close_token();
        bit empty_image;
        in_token = 1'b0;
        case (phase)
            pbm_pkg::PH_MAGIC:
            begin
                if (magic_ok && token_len == 2'd2)
                    phase = pbm_pkg::PH_WIDTH;
                else
                    add_result(pbm_pkg::KIND_BAD_MAGIC, 1'b0, 0, 0, 0, 0, 1'b0);
            end
            pbm_pkg::PH_WIDTH:
            begin
                if (number > DIM_LIMIT)
                begin
                    add_result(pbm_pkg::KIND_DIM_ERROR, 1'b0, 0, 0, clip16(number), 0, 1'b0);
                    phase = pbm_pkg::PH_MAGIC;
                end
                else
                begin
                    img_width = number;
                    phase = pbm_pkg::PH_HEIGHT;
                end
            end
            default:
            begin
                if (number > DIM_LIMIT)
                begin
                    add_result(pbm_pkg::KIND_DIM_ERROR, 1'b0, 0, 0, img_width, clip16(number),
                               1'b0);
                    phase = pbm_pkg::PH_MAGIC;
                end
                else
                begin
                    img_height = number;
                    col_count = 0;
                    row_count = 0;
                    empty_image = (img_width == 0 || img_height == 0);
                    add_result(pbm_pkg::KIND_HEADER, 1'b0, 0, 0, img_width, img_height,
                               empty_image);
                    phase = empty_image ? pbm_pkg::PH_MAGIC : pbm_pkg::PH_RASTER;
                end
            end
        endcase
    endfunction

    function void take_token_char(logic [7:0] b);
        if (phase == pbm_pkg::PH_MAGIC)
        begin
            if (token_len == 2'd0)
            begin
                if (b != pbm_pkg::CHAR_P)
                    magic_ok = 1'b0;
            end
            else if (token_len == 2'd1)
            begin
                if (b == pbm_pkg::CHAR_ONE)
                    binary_mode = 1'b0;
                else if (b == pbm_pkg::CHAR_FOUR)
                    binary_mode = 1'b1;
                else
                    magic_ok = 1'b0;
            end
            else
                magic_ok = 1'b0;
            if (token_len != 2'd3)
                token_len++;
        end
        else if (!digits_ended && b >= pbm_pkg::CHAR_ZERO && b <= pbm_pkg::CHAR_NINE)
        begin
            // The accumulator saturates one above the limit so oversize stays oversize.
            number = number * 10 + (b - pbm_pkg::CHAR_ZERO);
            if (number > DIM_LIMIT + 1)
                number = DIM_LIMIT + 1;
        end
        else
            digits_ended = 1'b1;
    endfunction

    // Works out the results of one accepted byte and queues them.
    function void note_byte(logic [7:0] b);
        int unsigned start_row;
        pbm_result_t tail;
        byte_results.delete();
        if (phase == pbm_pkg::PH_RASTER)
        begin
            if (binary_mode)
            begin
                // Padding bits after a row end and bits after the image end are dropped.
                for (int k = 7; k >= 0; k--)
                begin
                    start_row = row_count;
                    add_pixel(b[k]);
                    if (phase != pbm_pkg::PH_RASTER || row_count != start_row)
                        break;
                end
            end
            else if (!is_blank(b))
                add_pixel(b == pbm_pkg::CHAR_ONE);
        end
        else if (in_comment)
        begin
            if (b == pbm_pkg::CHAR_LF)
                in_comment = 1'b0;
        end
        else if (is_blank(b))
        begin
            if (in_token)
                close_token();
        end
        else if (!in_token && b == pbm_pkg::CHAR_HASH)
            in_comment = 1'b1;
        else
        begin
            if (!in_token)
            begin
                in_token = 1'b1;
                token_len = 2'd0;
                magic_ok = 1'b1;
                digits_ended = 1'b0;
                number = 0;
            end
            take_token_char(b);
        end
        if (byte_results.size() != 0)
        begin
            tail = byte_results.pop_back();
            tail.last = 1'b1;
            byte_results.push_back(tail);
        end
        foreach (byte_results[i])
            awaited_results.push_back(byte_results[i]);
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task compare_field(string name, int unsigned got_v, int unsigned exp_v);
        if (got_v != exp_v)
            report($sformatf("result %0d: %s is %0d, expected %0d", checked, name, got_v,
                             exp_v));
    endtask

    task check_result(pbm_result_t got);
        pbm_result_t exp;
        if (awaited_results.size() == 0)
            report($sformatf("result %0d: unexpected transaction, kind %0d col %0d row %0d",
                             checked, got.kind, got.column, got.row));
        else
        begin
            exp = awaited_results.pop_front();
            compare_field("kind", got.kind, exp.kind);
            compare_field("pixel", got.pixel, exp.pixel);
            compare_field("column", got.column, exp.column);
            compare_field("row", got.row, exp.row);
            compare_field("width", got.width, exp.width);
            compare_field("height", got.height, exp.height);
            compare_field("end_of_image", got.end_of_image, exp.end_of_image);
            compare_field("last", got.last, exp.last);
        end
        checked++;
    endtask
endclass

module pbm_bitmap_stream_decoder_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic        pixel;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] width;
    logic [15:0] height;
    logic        end_of_image;
    logic        last;

    pbm_scoreboard sb;
    bit            calm = 1'b0;
    int            fed = 0;
    bit [7:0]      file_bytes[$];

    pbm_bitmap_stream_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .pixel        (pixel),
        .column       (column),
        .row          (row),
        .width        (width),
        .height       (height),
        .end_of_image (end_of_image),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endfunction

    function automatic bit [7:0] blank_byte();
        bit [7:0] blanks[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        return blanks[$urandom_range(0, 5)];
    endfunction

    function automatic void put_blank();
        repeat ($urandom_range(1, 2))
            file_bytes.push_back(blank_byte());
    endfunction

    // A comment body may hold any byte but a line feed.
    function automatic void put_comment();
        bit [7:0] b;
        file_bytes.push_back(pbm_pkg::CHAR_HASH);
        repeat ($urandom_range(0, 5))
        begin
            b = 8'($urandom_range(0, 255));
            if (b == pbm_pkg::CHAR_LF)
                b = 8'hC5;
            file_bytes.push_back(b);
        end
        file_bytes.push_back(pbm_pkg::CHAR_LF);
    endfunction

    function automatic void put_sep();
        put_blank();
        if ($urandom_range(0, 5) == 0)
            put_comment();
    endfunction

    // Writes one dimension token and returns the value the decoder will take,
    // or -1 when it is oversize.
    function automatic int put_dim(int max_small);
        int v;
        v = $urandom_range(1, max_small);
        case ($urandom_range(0, 19))
            0:
            begin
                put_text("0");
                return 0;
            end
            1:
            begin
                case ($urandom_range(0, 2))
                    0: put_text("65536");
                    1: put_text("70000");
                    default: put_text("4294967296");
                endcase
                return -1;
            end
            2:
            begin
                put_text($urandom_range(0, 1) ? "+7" : "-5");
                return 0;
            end
            3:
            begin
                put_text($sformatf("%0dz%0d", v, $urandom_range(0, 9)));
                return v;
            end
            4:
            begin
                put_text($sformatf("00%0d", v));
                return v;
            end
            default:
            begin
                put_text($sformatf("%0d", v));
                return v;
            end
        endcase
    endfunction

    function automatic void build_file();
        string bad_magic[7] = '{"P2", "P", "P14", "p1", "P1#", "1P", "P4P"};
        int w;
        int h;
        bit p4;
        bit [7:0] b;
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 6))
                file_bytes.push_back(8'($urandom_range(0, 255)));
            file_bytes.push_back(pbm_pkg::CHAR_LF);
        end
        if ($urandom_range(0, 3) == 0)
            put_sep();
        if ($urandom_range(0, 9) == 0)
        begin
            put_text(bad_magic[$urandom_range(0, 6)]);
            put_blank();
            return;
        end
        p4 = 1'($urandom_range(0, 1));
        put_text(p4 ? "P4" : "P1");
        put_sep();
        if ($urandom_range(0, 24) == 0)
        begin
            // Largest legal dimension, paired with a zero so the image is empty.
            put_text($urandom_range(0, 1) ? "65535 0" : "0 65535");
            put_blank();
            return;
        end
        w = put_dim(p4 ? 20 : 10);
        put_sep();
        if (w < 0)
            return;
        h = put_dim(4);
        // Once the header is complete a single byte ends the height token.
        file_bytes.push_back(blank_byte());
        if (h <= 0 || w == 0)
            return;
        if (p4)
        begin
            repeat (h * ((w + 7) / 8))
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat (w * h)
            begin
                if ($urandom_range(0, 3) == 0)
                    put_blank();
                if ($urandom_range(0, 9) == 0)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (is_blank(b));
                end
                else
                    b = $urandom_range(0, 1) ? pbm_pkg::CHAR_ONE : pbm_pkg::CHAR_ZERO;
                file_bytes.push_back(b);
            end
        end
        if ($urandom_range(0, 1) == 0)
            put_blank();
    endfunction

    task send_byte(input bit [7:0] b);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 8))
            begin
                @(negedge clk);
                push <= 1'b0;
            end
        end
        @(negedge clk);
        push <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        sb.note_byte(b);
        fed++;
        if (fed >= 330)
            calm = 1'b1;
    endtask

    task send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i]);
        file_bytes.delete();
    endtask

    task wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Binary one-pixel image, ASCII image followed by a comment, then a
        // signed width that counts as zero and gives an empty image.
        put_text("P4 1 1\n");
        file_bytes.push_back(8'hFF);
        put_text("P1 2 1 1x#\nP4 -3 7 ");
        send_file();
        @(negedge clk);
        push <= 1'b0;
        wait_drained();

        fed = 0;
        while (fed < 400)
        begin
            build_file();
            send_file();
        end
        @(negedge clk);
        push <= 1'b0;
        wait_drained();
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("pbm_bitmap_stream_decoder_tb: done, clean");
        else
            $display("pbm_bitmap_stream_decoder_tb: done, errors");
        $finish;
    end

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                pop <= 1'b0;
            else
            begin
                if (stall == 0 && !calm && $urandom_range(0, 5) == 0)
                    stall = $urandom_range(1, 8);
                if (stall > 0)
                begin
                    pop <= 1'b0;
                    stall--;
                end
                else
                    pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        pbm_result_t got;
        if (rst_n && pop && !empty)
        begin
            got = {kind, pixel, column, row, width, height, end_of_image, last};
            sb.check_result(got);
        end
    end

    initial
    begin
        #5000000;
        $display("pbm_bitmap_stream_decoder_tb: done, errors");
        $finish;
    end

endmodule
